### rtl/fcbt_pkg.sv
// ----------------------------------------------------------------------------
// fcbt_pkg
// Shared types and constants for the frustum cull box test block.
// ----------------------------------------------------------------------------
`default_nettype none
package fcbt_pkg;
  localparam int unsigned CornerCount  = 8;
  localparam int unsigned FractionBits = 16;
  localparam int unsigned CntW         = $clog2(CornerCount + 1);
  localparam int unsigned QuoW         = 32 + FractionBits + 1;

  localparam logic [2:0] CFG_MIN_X = 3'd0;
  localparam logic [2:0] CFG_MIN_Y = 3'd1;
  localparam logic [2:0] CFG_MIN_Z = 3'd2;
  localparam logic [2:0] CFG_MAX_X = 3'd3;
  localparam logic [2:0] CFG_MAX_Y = 3'd4;
  localparam logic [2:0] CFG_MAX_Z = 3'd5;

  localparam logic ACT_ROW    = 1'b0;
  localparam logic ACT_CORNER = 1'b1;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef struct packed {
    logic       load_row;
    logic       load_vec;
    logic       mac_clr;
    logic       mac_en;
    logic [1:0] mac_row;
    logic [1:0] mac_col;
    logic       clip_wr;
    logic [1:0] clip_row;
    logic       div_start;
    logic [1:0] div_axis;
    logic       box_upd;
    logic       box_clr;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } sts_t;
endpackage
`default_nettype wire

### rtl/fcbt_if.sv
// ----------------------------------------------------------------------------
// fcbt_in_if / fcbt_out_if / fcbt_cfg_if
// Valid/ready channels of the frustum cull box test block.
// ----------------------------------------------------------------------------
`default_nettype none
interface fcbt_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [1:0]         row_index;
  logic signed [31:0] value_x;
  logic signed [31:0] value_y;
  logic signed [31:0] value_z;
  logic signed [31:0] value_w;
  modport source (output valid, action, row_index, value_x, value_y, value_z, value_w,
                  input ready);
  modport sink (input valid, action, row_index, value_x, value_y, value_z, value_w,
                output ready);
endinterface

interface fcbt_out_if;
  logic valid;
  logic ready;
  logic cullable;
  logic zero_w_seen;
  modport source (output valid, cullable, zero_w_seen, input ready);
  modport sink (input valid, cullable, zero_w_seen, output ready);
endinterface

interface fcbt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/frustum_cull_box_test_top.sv
// ----------------------------------------------------------------------------
// frustum_cull_box_test_top
// Channel   Direction  Payload
// in_       sink       action, row_index, value_x..value_w
// out_      source     cullable, zero_w_seen
// cfg_      sink       index (0..5), data
// A corner runs its multiply-adds on the one shared 32x32 multiplier, then
// three divides, each through start, 49 quotient bits, done and box update,
// before the next input is accepted. With transformed w of zero each divide
// skips its quotient bits. The last corner of a set passes through the output
// and clear states and holds the result until taken.
// Reset is synchronous; the matrix is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module frustum_cull_box_test_top (
  input  wire logic clk,
  input  wire logic rst_n,
  fcbt_in_if.sink   in_ch,
  fcbt_out_if.source out_ch,
  fcbt_cfg_if.sink  cfg_ch
);
  fcbt_pkg::cmd_t     cmd;
  fcbt_pkg::sts_t     sts;
  logic signed [31:0] fmin_r [3];
  logic signed [31:0] fmax_r [3];
  logic               cull, zw;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        fmin_r[i] <= -(32'sd1 <<< fcbt_pkg::FractionBits);
        fmax_r[i] <= (32'sd1 <<< fcbt_pkg::FractionBits);
      end
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        fcbt_pkg::CFG_MIN_X: fmin_r[0] <= cfg_ch.data;
        fcbt_pkg::CFG_MIN_Y: fmin_r[1] <= cfg_ch.data;
        fcbt_pkg::CFG_MIN_Z: fmin_r[2] <= cfg_ch.data;
        fcbt_pkg::CFG_MAX_X: fmax_r[0] <= cfg_ch.data;
        fcbt_pkg::CFG_MAX_Y: fmax_r[1] <= cfg_ch.data;
        fcbt_pkg::CFG_MAX_Z: fmax_r[2] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  fcbt_pkg::cmd_t cmd_raw;

  fcbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd_raw),
    .sts       (sts)
  );

  fcbt_acc u_acc (
    .cmd_in  (cmd_raw),
    .in_mac  (cmd_raw.mac_en | cmd_raw.clip_wr),
    .cmd_out (cmd)
  );

  fcbt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .row_index (in_ch.row_index),
    .vx        (in_ch.value_x),
    .vy        (in_ch.value_y),
    .vz        (in_ch.value_z),
    .vw        (in_ch.value_w),
    .fmin      (fmin_r),
    .fmax      (fmax_r),
    .cullable  (cull),
    .zero_w    (zw)
  );

  logic cull_r, zw_r;
  always_ff @(posedge clk) begin
    if (cmd_raw.box_clr) begin
      cull_r <= cull;
      zw_r   <= zw;
    end
  end
  assign out_ch.cullable    = cull_r;
  assign out_ch.zero_w_seen = zw_r;
endmodule
`default_nettype wire

### rtl/fcbt_div.sv
// ----------------------------------------------------------------------------
// fcbt_div
// Restoring divider, one quotient bit a cycle: sat32(num * 2^F / |den|).
// ----------------------------------------------------------------------------
`default_nettype none
module fcbt_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output logic                    busy,
  output logic signed [31:0]      quo
);
  localparam int unsigned QW = fcbt_pkg::QuoW;
  localparam int unsigned BW = $clog2(QW + 1);

  logic [QW-1:0] dvd_r, dvd_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [31:0]   dvs_r, dvs_nxt;
  logic          neg_r, neg_nxt;
  logic [BW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [33:0]   trial;
  logic [32:0]   mag;
  logic [32:0]   amag;

  always_comb begin
    trial = {rem_r, dvd_r[QW-1]} - {2'b00, dvs_r};
    mag   = num[31] ? 33'(-{num[31], num}) : {1'b0, num};
    amag  = den[31] ? 33'(-{den[31], den}) : {1'b0, den};
  end

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      dvd_nxt  = QW'({mag, {fcbt_pkg::FractionBits{1'b0}}});
      rem_nxt  = '0;
      dvs_nxt  = amag[31:0];
      neg_nxt  = num[31];
      cnt_nxt  = BW'(QW);
      busy_nxt = (amag != '0);
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        dvd_nxt = {dvd_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], dvd_r[QW-1]};
        dvd_nxt = {dvd_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == BW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) busy_r <= 1'b0;
    else        busy_r <= busy_nxt;
  end

  logic zero_den_r;
  always_ff @(posedge clk) begin
    if (start) zero_den_r <= (amag == '0);
  end

  always_comb begin
    busy = busy_r;
    if (zero_den_r) begin
      if (dvd_r == '0)  quo = '0;
      else if (neg_r)   quo = fcbt_pkg::S32_MIN;
      else              quo = fcbt_pkg::S32_MAX;
    end else if (neg_r) begin
      if (dvd_r > QW'(33'h080000000)) quo = fcbt_pkg::S32_MIN;
      else                            quo = 32'(-dvd_r);
    end else begin
      if (dvd_r > QW'(33'h07fffffff)) quo = fcbt_pkg::S32_MAX;
      else                            quo = dvd_r[31:0];
    end
  end
endmodule
`default_nettype wire

### rtl/fcbt_dp.sv
// ----------------------------------------------------------------------------
// fcbt_dp
// Datapath: matrix store, shared multiply-accumulate, divider, box and test.
// ----------------------------------------------------------------------------
`default_nettype none
module fcbt_dp (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire fcbt_pkg::cmd_t         cmd,
  output fcbt_pkg::sts_t              sts,
  input  wire logic [1:0]             row_index,
  input  wire logic signed [31:0]     vx,
  input  wire logic signed [31:0]     vy,
  input  wire logic signed [31:0]     vz,
  input  wire logic signed [31:0]     vw,
  input  wire logic signed [31:0]     fmin [3],
  input  wire logic signed [31:0]     fmax [3],
  output logic                        cullable,
  output logic                        zero_w
);
  localparam int unsigned F = fcbt_pkg::FractionBits;

  logic signed [31:0] mat_r [16];
  logic signed [31:0] vec_r [4];
  logic signed [31:0] clip_r [4];
  logic signed [31:0] bmin_r [3];
  logic signed [31:0] bmax_r [3];
  logic signed [63:0] prod_r;
  logic signed [49:0] acc_r;
  logic               zw_r;
  logic signed [31:0] mul_a, mul_b, quo, sat_acc;
  logic signed [49:0] term, sum;
  logic               div_busy;

  always_comb begin
    mul_a = mat_r[{cmd.mac_row, cmd.mac_col}];
    mul_b = vec_r[cmd.mac_col];
    term  = 50'(prod_r >>> F);
    sum   = acc_r + term;
    if (sum > 50'sh0007fffffff)       sat_acc = fcbt_pkg::S32_MAX;
    else if (sum < -50'sh00080000000) sat_acc = fcbt_pkg::S32_MIN;
    else                              sat_acc = sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_row) begin
      mat_r[{row_index, 2'd0}] <= vx;
      mat_r[{row_index, 2'd1}] <= vy;
      mat_r[{row_index, 2'd2}] <= vz;
      mat_r[{row_index, 2'd3}] <= vw;
    end
    if (cmd.load_vec) begin
      vec_r[0] <= vx;
      vec_r[1] <= vy;
      vec_r[2] <= vz;
      vec_r[3] <= vw;
    end
    prod_r <= 64'(mul_a) * 64'(mul_b);
    if (cmd.mac_en) acc_r <= cmd.mac_clr ? term : sum;
    if (cmd.clip_wr) clip_r[cmd.clip_row] <= sat_acc;
  end

  fcbt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (clip_r[cmd.div_axis]),
    .den   (clip_r[3]),
    .busy  (div_busy),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.box_clr) begin
      for (int i = 0; i < 3; i++) begin
        bmin_r[i] <= fcbt_pkg::S32_MAX;
        bmax_r[i] <= fcbt_pkg::S32_MIN;
      end
      zw_r <= 1'b0;
    end else if (cmd.box_upd) begin
      if (quo < bmin_r[cmd.div_axis]) bmin_r[cmd.div_axis] <= quo;
      if (quo > bmax_r[cmd.div_axis]) bmax_r[cmd.div_axis] <= quo;
      if (clip_r[3] == '0) zw_r <= 1'b1;
    end
  end

  always_comb begin
    sts.div_busy = div_busy;
    cullable = 1'b0;
    for (int i = 0; i < 3; i++)
      if (!(bmin_r[i] <= fmax[i] && bmax_r[i] >= fmin[i])) cullable = 1'b1;
    zero_w = zw_r;
  end
endmodule
`default_nettype wire

### rtl/fcbt_ctrl.sv
// ----------------------------------------------------------------------------
// fcbt_ctrl
// Sequencer: row loads, sixteen multiply-adds, three divides, box updates, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module fcbt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_action,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output fcbt_pkg::cmd_t      cmd,
  input  wire fcbt_pkg::sts_t sts
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_DIVS = 3'd2;
  localparam logic [2:0] S_DIVW = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_CLR  = 3'd6;
  localparam int unsigned CW = fcbt_pkg::CntW;

  logic [2:0]    st_r, st_nxt;
  logic [4:0]    step_r, step_nxt;
  logic [4:0]    step_prev;
  logic [1:0]    axis_r, axis_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ov_r, ov_nxt;
  logic          acc_in;

  assign in_ready  = (st_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign acc_in    = in_valid && in_ready;

  always_comb begin
    st_nxt    = st_r;
    step_nxt  = step_r;
    step_prev = step_r - 5'd1;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    cmd.mac_row  = step_r[3:2];
    cmd.div_axis = axis_r;
    case (st_r)
      S_IDLE: begin
        if (acc_in) begin
          if (in_action == fcbt_pkg::ACT_ROW) begin
            cmd.load_row = 1'b1;
          end else begin
            cmd.load_vec = 1'b1;
            st_nxt       = S_MAC;
            step_nxt     = '0;
          end
        end
      end
      S_MAC: begin
        // issue product at step, accumulate the previous one
        cmd.mac_row = step_r[3:2];
        cmd.mac_col = step_r[1:0];
        if (step_r != 5'd0) begin
          cmd.mac_en   = 1'b1;
          cmd.mac_clr  = (step_prev[1:0] == 2'd0);
          cmd.clip_wr  = (step_prev[1:0] == 2'd3);
          cmd.clip_row = step_prev[3:2];
        end
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd16) begin
          st_nxt   = S_DIVS;
          axis_nxt = '0;
        end
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        st_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (!sts.div_busy) st_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.box_upd = 1'b1;
        if (axis_r == 2'd2) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CW'(fcbt_pkg::CornerCount - 1)) st_nxt = S_OUT;
          else st_nxt = S_IDLE;
        end else begin
          axis_nxt = axis_r + 2'd1;
          st_nxt   = S_DIVS;
        end
      end
      S_OUT: begin
        st_nxt = S_CLR;
      end
      S_CLR: begin
        cmd.box_clr = 1'b1;
        ov_nxt  = 1'b1;
        cnt_nxt = '0;
        st_nxt  = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    axis_r <= axis_nxt;
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/fcbt_acc.sv
// ----------------------------------------------------------------------------
// fcbt_acc
// Accumulator sequencing fix-up: suppresses the sum clear on a clip-row write.
// ----------------------------------------------------------------------------
`default_nettype none
module fcbt_acc (
  input  wire fcbt_pkg::cmd_t cmd_in,
  input  wire logic           in_mac,
  output fcbt_pkg::cmd_t      cmd_out
);
  always_comb begin
    cmd_out = cmd_in;
    // no clear on a clip-row write, pass the rest of the command through
    if (in_mac && cmd_in.clip_wr) cmd_out.mac_clr = 1'b0;
  end
endmodule
`default_nettype wire
